[design/alt_pkg.sv]
// Shared types and constants for the address lease table.
// Used by the cells, the hash/modulo unit, the top level and the checker.
package alt_pkg;

  localparam int DEF_LEASE_ENTRIES = 256;
  localparam int DEF_PROBE_LIMIT   = 64;

  localparam int MAC_W    = 48;
  localparam int ADDR_W   = 40;
  localparam int TIME_W   = 32;
  localparam int HASH_W   = 32;
  localparam int SPAN_W   = ADDR_W + 1;
  localparam int HASH_STEPS = MAC_W / 8;
  localparam int DIV_STEPS  = HASH_W;
  localparam int HASH_SHIFT = 5;   // h*31 = (h << 5) - h

  localparam logic [ADDR_W-1:0] RESET_POOL_FIRST    = ADDR_W'(16);
  localparam logic [ADDR_W-1:0] RESET_POOL_LAST     = ADDR_W'(254);
  localparam logic [TIME_W-1:0] RESET_LEASE_SECONDS = TIME_W'(3600);

  typedef enum logic [1:0] {
    KIND_DISCOVER = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RELEASE  = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OFFER           = 3'd0,
    ST_ACK             = 3'd1,
    ST_REFUSED         = 3'd2,
    ST_FULL            = 3'd3,
    ST_RELEASED        = 3'd4,
    ST_RELEASE_IGNORED = 3'd5
  } status_t;

  localparam logic [1:0] CFG_POOL_FIRST    = 2'd0;
  localparam logic [1:0] CFG_POOL_LAST     = 2'd1;
  localparam logic [1:0] CFG_LEASE_SECONDS = 2'd2;

  // query token walking down the cell row
  typedef struct packed {
    logic              vld;
    logic [MAC_W-1:0]  mac;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic              found;
    logic [ADDR_W-1:0] found_addr;
    logic              free_found;
    logic              held;
  } tok_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CLEAR = 2'd1,
    WR_RENEW = 2'd2,
    WR_FILL  = 2'd3
  } wr_op_t;

  // entry update broadcast to the row
  typedef struct packed {
    wr_op_t            op;
    logic [MAC_W-1:0]  mac;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] expiry;
  } wr_t;

endpackage

[design/alt_req_if.sv]
// Request channel: valid/ready plus one lease operation.
// Depends on alt_pkg for field widths.
interface alt_req_if import alt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [MAC_W-1:0]  client_mac;
  logic [ADDR_W-1:0] asked_address;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, kind, client_mac, asked_address, now_seconds, input ready);
  modport sink   (input valid, kind, client_mac, asked_address, now_seconds, output ready);
endinterface

[design/alt_rsp_if.sv]
// Response channel: valid/ready plus status and granted address.
// Depends on alt_pkg for field widths.
interface alt_rsp_if import alt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

[design/alt_cfg_if.sv]
// Configuration write channel: valid/ready, register index and data.
// Depends on alt_pkg for the data width.
interface alt_cfg_if import alt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [ADDR_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/alt_cell.sv]
// One lease entry of the table plus its stage of the query row.
// Depends on alt_pkg (tok_t, wr_t).
module alt_cell import alt_pkg::*; #(
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  tok_t          tok_in,
  input  logic [IW-1:0] fidx_in,
  input  logic [IW-1:0] ridx_in,
  output tok_t          tok_out,
  output logic [IW-1:0] fidx_out,
  output logic [IW-1:0] ridx_out,
  input  wr_t           wr,
  input  logic [IW-1:0] wr_idx
);

  logic              valid;
  logic [MAC_W-1:0]  mac;
  logic [ADDR_W-1:0] addr;
  logic [TIME_W-1:0] expiry;

  logic          sel;
  logic          hit, free, held;
  tok_t          tok_next;
  logic [IW-1:0] fidx_next, ridx_next;

  assign sel = (wr_idx == IW'(IDX));

  always_comb begin
    hit  = valid && (mac == tok_in.mac);
    free = !valid || (expiry <= tok_in.now);
    held = valid && (addr == tok_in.addr) && (expiry > tok_in.now);
    tok_next  = tok_in;
    fidx_next = fidx_in;
    ridx_next = ridx_in;
    // lowest matching entry wins
    if (!tok_in.found && hit) begin
      tok_next.found      = 1'b1;
      tok_next.found_addr = addr;
      fidx_next           = IW'(IDX);
    end
    if (!tok_in.free_found && free) begin
      tok_next.free_found = 1'b1;
      ridx_next           = IW'(IDX);
    end
    tok_next.held = tok_in.held || held;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    fidx_out <= fidx_next;
    ridx_out <= ridx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      unique case (wr.op)
        WR_CLEAR: valid <= 1'b0;
        WR_FILL:  valid <= 1'b1;
        WR_NONE, WR_RENEW: valid <= valid;
        default:  valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.op == WR_FILL) begin
      mac  <= wr.mac;
      addr <= wr.addr;
    end
    if (sel && (wr.op == WR_FILL || wr.op == WR_RENEW)) begin
      expiry <= wr.expiry;
    end
  end

endmodule

[design/alt_hashmod.sv]
// MAC hash (one byte a cycle) followed by restoring modulo by the pool span
// (one bit a cycle). Depends on alt_pkg.
module alt_hashmod import alt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAC_W-1:0]  mac,
  input  logic [SPAN_W-1:0] span,
  output logic              done,
  output logic [HASH_W-1:0] rem
);

  localparam int CW = $clog2(HASH_STEPS + DIV_STEPS);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [MAC_W-1:0]  sh;
  logic [HASH_W-1:0] h;
  logic [HASH_W:0]   r;
  logic [SPAN_W-1:0] sp;
  logic [HASH_W:0]   rs;

  assign rs  = {r[HASH_W-1:0], h[HASH_W-1]};
  assign rem = r[HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(HASH_STEPS + DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= mac;
      h  <= '0;
      r  <= '0;
      sp <= span;
    end else if (busy) begin
      if (cnt < CW'(HASH_STEPS)) begin
        h  <= (h << HASH_SHIFT) - h + HASH_W'(sh[MAC_W-1 -: 8]);
        sh <= sh << 8;
      end else begin
        h <= h << 1;
        if (SPAN_W'(rs) >= sp) begin
          r <= rs - sp[HASH_W:0];
        end else begin
          r <= rs;
        end
      end
    end
  end

endmodule

[design/address_lease_table.sv]
// Address lease table: top level with the cell row, sequencer and config.
// Depends on alt_pkg, the channel interfaces, alt_cell and alt_hashmod.
//
// Channels: req carries one operation (discover, request, release) per
// transfer; rsp returns exactly one status/address per operation, in order;
// cfg writes pool_first (0), pool_last (1) or lease_seconds (2) and is
// always ready. Each cell of the row holds one lease; a query token walks
// the row one cell per cycle and gathers the client match, the first free
// or expired entry and whether its address is held.
// Renew, release or refusal: the response follows the row walk and the
// hash plus bitwise modulo, which run side by side; a new lease then
// streams the PROBE_LIMIT+1 probe addresses through the row back to back.
// One operation is worked at a time; req.ready is high only when idle.
// A result waits in the output register while the next request is taken;
// a stalled receiver holds the block before it delivers its next result.
// Reset empties the table (valid bits only) and restores the registers.
module address_lease_table import alt_pkg::*; #(
  parameter int LEASE_ENTRIES = DEF_LEASE_ENTRIES,
  parameter int PROBE_LIMIT   = DEF_PROBE_LIMIT
) (
  input  logic   clk,
  input  logic   rst,
  alt_cfg_if.sink   cfg,
  alt_req_if.sink   req,
  alt_rsp_if.source rsp
);

  localparam int IW  = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
  localparam int PCW = $clog2(PROBE_LIMIT + 2);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_LWAIT = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_PROBE = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0] pool_first, pool_last;
  logic [TIME_W-1:0] lease_seconds;

  logic [1:0]        r_kind;
  logic [MAC_W-1:0]  r_mac;
  logic [ADDR_W-1:0] r_asked;
  logic [TIME_W-1:0] r_now;

  logic              lk_found, lk_free;
  logic [IW-1:0]     lk_fidx, lk_ridx;
  logic [ADDR_W-1:0] lk_faddr;

  logic [ADDR_W-1:0] pa;
  logic [PCW-1:0]    pc, rc;
  logic              got;
  logic [ADDR_W-1:0] got_addr;

  logic [2:0]        res_status;
  logic [ADDR_W-1:0] res_addr;

  tok_t          tok  [0:LEASE_ENTRIES];
  logic [IW-1:0] fidx [0:LEASE_ENTRIES];
  logic [IW-1:0] ridx [0:LEASE_ENTRIES];
  tok_t          tail;

  wr_t           wr;
  logic [IW-1:0] wr_idx;

  logic              hm_start, hm_done;
  logic [HASH_W-1:0] hm_rem;
  logic [SPAN_W-1:0] span;

  logic              req_xfer;
  logic [TIME_W:0]   exp_sum;
  logic [TIME_W-1:0] exp_new;

  assign req_xfer  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign tail      = tok[LEASE_ENTRIES];
  assign hm_start  = req_xfer;
  assign span      = {1'b0, pool_last} - {1'b0, pool_first} + SPAN_W'(1);

  assign exp_sum = {1'b0, r_now} + {1'b0, lease_seconds};
  assign exp_new = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_first    <= RESET_POOL_FIRST;
      pool_last     <= RESET_POOL_LAST;
      lease_seconds <= RESET_LEASE_SECONDS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_POOL_FIRST:    pool_first    <= cfg.data;
        CFG_POOL_LAST:     pool_last     <= cfg.data;
        CFG_LEASE_SECONDS: lease_seconds <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  alt_hashmod u_hashmod (
    .clk   (clk),
    .rst   (rst),
    .start (hm_start),
    .mac   (req.client_mac),
    .span  (span),
    .done  (hm_done),
    .rem   (hm_rem)
  );

  // token injected at the head of the row
  always_comb begin
    tok[0]  = '0;
    fidx[0] = '0;
    ridx[0] = '0;
    if (state == S_LOOK || (state == S_PROBE && pc <= PCW'(PROBE_LIMIT))) begin
      tok[0].vld  = 1'b1;
      tok[0].mac  = r_mac;
      tok[0].addr = (state == S_PROBE) ? pa : '0;
      tok[0].now  = r_now;
    end
  end

  for (genvar g = 0; g < LEASE_ENTRIES; g++) begin : g_cell
    alt_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[g]),
      .fidx_in  (fidx[g]),
      .ridx_in  (ridx[g]),
      .tok_out  (tok[g+1]),
      .fidx_out (fidx[g+1]),
      .ridx_out (ridx[g+1]),
      .wr       (wr),
      .wr_idx   (wr_idx)
    );
  end

  // entry updates
  always_comb begin
    wr        = '0;
    wr.op     = WR_NONE;
    wr.mac    = r_mac;
    wr.addr   = got_addr;
    wr.expiry = exp_new;
    wr_idx    = lk_fidx;
    if (state == S_DEC && hm_done) begin
      if (r_kind == KIND_RELEASE) begin
        if (lk_found && (r_asked == '0 || lk_faddr == r_asked)) begin
          wr.op = WR_CLEAR;
        end
      end else if (r_kind != KIND_UNUSED && lk_found) begin
        wr.op = WR_RENEW;
      end
    end else if (state == S_FILL && got) begin
      wr.op  = WR_FILL;
      wr_idx = lk_ridx;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_xfer) state_next = S_LOOK;
      S_LOOK:  state_next = S_LWAIT;
      S_LWAIT: if (tail.vld) state_next = S_DEC;
      S_DEC: begin
        if (hm_done) begin
          if (r_kind != KIND_DISCOVER && r_kind != KIND_REQUEST) begin
            state_next = S_DONE;
          end else if (lk_found || pool_last < pool_first || !lk_free) begin
            state_next = S_DONE;
          end else begin
            state_next = S_PROBE;
          end
        end
      end
      S_PROBE: if (tail.vld && rc == PCW'(PROBE_LIMIT)) state_next = S_FILL;
      S_FILL:  state_next = S_DONE;
      S_DONE:  if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      r_kind  <= req.kind;
      r_mac   <= req.client_mac;
      r_asked <= req.asked_address;
      r_now   <= req.now_seconds;
    end
    if (state == S_LWAIT && tail.vld) begin
      lk_found <= tail.found;
      lk_faddr <= tail.found_addr;
      lk_free  <= tail.free_found;
      lk_fidx  <= fidx[LEASE_ENTRIES];
      lk_ridx  <= ridx[LEASE_ENTRIES];
    end
    if (state == S_DEC) begin
      pa  <= pool_first + ADDR_W'(hm_rem);
      pc  <= '0;
      rc  <= '0;
      got <= 1'b0;
      if (r_kind == KIND_RELEASE) begin
        res_addr   <= '0;
        res_status <= (lk_found && (r_asked == '0 || lk_faddr == r_asked))
                      ? ST_RELEASED : ST_RELEASE_IGNORED;
      end else if (r_kind == KIND_UNUSED) begin
        res_addr   <= '0;
        res_status <= ST_RELEASE_IGNORED;
      end else if (lk_found) begin
        if (r_kind == KIND_DISCOVER) begin
          res_status <= ST_OFFER;
          res_addr   <= lk_faddr;
        end else if (lk_faddr == r_asked) begin
          res_status <= ST_ACK;
          res_addr   <= r_asked;
        end else begin
          res_status <= ST_REFUSED;
          res_addr   <= '0;
        end
      end else begin
        res_status <= ST_FULL;
        res_addr   <= '0;
      end
    end
    if (state == S_PROBE) begin
      if (pc <= PCW'(PROBE_LIMIT)) begin
        pc <= pc + PCW'(1);
        pa <= (pa == pool_last) ? pool_first : pa + ADDR_W'(1);
      end
      if (tail.vld) begin
        rc <= rc + PCW'(1);
        // first address in probe order that no live lease holds
        if (!tail.held && !got) begin
          got      <= 1'b1;
          got_addr <= tail.addr;
        end
      end
    end
    if (state == S_FILL) begin
      if (!got) begin
        res_status <= ST_FULL;
        res_addr   <= '0;
      end else if (r_kind == KIND_DISCOVER) begin
        res_status <= ST_OFFER;
        res_addr   <= got_addr;
      end else if (got_addr == r_asked) begin
        res_status <= ST_ACK;
        res_addr   <= r_asked;
      end else begin
        res_status <= ST_REFUSED;
        res_addr   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status          <= res_status;
      rsp.granted_address <= res_addr;
    end
  end

endmodule

[design/alt_checker.sv]
// Port-level checks for the address lease table, bound to the top level.
// Depends on alt_pkg for status codes.
module alt_checker import alt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        status,
  input logic [ADDR_W-1:0] granted_address
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_address))
    else $error("result changed while stalled");

  // one operation at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OFFER && status != ST_ACK |-> granted_address == '0)
    else $error("address on a non-grant status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_RELEASE_IGNORED)
    else $error("status out of range");

endmodule

bind address_lease_table alt_checker u_alt_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .status          (rsp.status),
  .granted_address (rsp.granted_address)
);
